/* hdl/sida_pkg.sv */
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the FSM state type and the BCD cell control struct.
// No dependencies.
package sida_pkg;

	// Input word width and number of BCD digit cells (2^32-1 has ten digits)
	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;

	// ASCII codes
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// Converter sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS,
		ST_NEWLINE
	} state_t;

	// Control broadcast to every BCD cell
	typedef struct packed {
		logic clear;   // zero the digit
		logic dabble;  // add-3 correction, then shift one binary bit in
		logic shift;   // take the digit of the lower neighbor
	} cell_ctrl_t;

endpackage

/* hdl/sida_cell.sv */
// One BCD digit cell of the double-dabble chain.
// Depends on sida_pkg (cell_ctrl_t).
module sida_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sida_pkg::cell_ctrl_t  ctrl,
	input  logic                  bit_in,
	input  logic [3:0]            digit_in,
	output logic                  bit_out,
	output logic [3:0]            digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add 3 when the digit would overflow past 9 after doubling
	always_comb begin
		adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
		bit_out = adj[3];
		digit   = digit_q;
	end

	// digit register: clear, binary shift, or digit hand-off toward the top cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

/* hdl/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text, one character per transfer.
// Depends on sida_pkg and sida_cell.
//
//   channel | signals                             | dir | meaning
//   input   | in_valid, in_stall, value,          | in  | one integer per transfer
//           | append_newline                      |     |
//   output  | out_valid, out_stall, char_code,    | out | one character per transfer,
//           | last                                |     | last marks end of text
//
// Each item runs through an accept step, 32 double-dabble shifts through the ten-cell
// BCD chain, a sign step for negative values, a step for each digit cell (leading
// zeros are dropped there) and, if requested, a newline step.
// Reset is asynchronous, active low, and returns the sequencer to idle with the
// output empty. A stalled output holds its character and stalls the sequencer only in
// states that emit; the next integer is taken while the final character still waits.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic        append_newline,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_code,
	output logic        last
);

	localparam int BCNT_W = $clog2(sida_pkg::VALUE_W);
	localparam int DCNT_W = $clog2(sida_pkg::NUM_DIGITS + 1);

	sida_pkg::state_t      state_q, state_d;
	sida_pkg::cell_ctrl_t  ctrl;

	logic [sida_pkg::VALUE_W-1:0]  mag_q;
	logic [sida_pkg::VALUE_W-1:0]  mag_w;
	logic                          neg_q;
	logic                          nl_q;
	logic [BCNT_W-1:0]             bcnt_q;
	logic [DCNT_W-1:0]             dcnt_q;
	logic                          started_q;

	logic                          out_valid_q;
	logic [7:0]                    char_q;
	logic                          last_q;

	logic [sida_pkg::NUM_DIGITS-1:0]       bit_chain;
	logic [sida_pkg::NUM_DIGITS-1:0][3:0]  digits_w;
	logic [sida_pkg::NUM_DIGITS-1:0][3:0]  digit_in_w;
	logic [3:0]                            digit_top;

	logic        accept;
	logic        out_free;
	logic        skip;
	logic        emit;
	logic [7:0]  emit_char;
	logic        emit_last;

	// magnitude; the most negative value maps to 2^31, which fits unsigned
	assign mag_w = value[31] ? (~value + 32'd1) : value;

	// BCD cell chain: binary bits enter at cell 0, digits leave from the top cell
	assign bit_chain[0] = mag_q[sida_pkg::VALUE_W-1];
	genvar gi;
	generate
		for (gi = 0; gi < sida_pkg::NUM_DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign digit_in_w[gi] = 4'd0;
			end else begin : g_rest
				assign digit_in_w[gi] = digits_w[gi-1];
			end
			if (gi == sida_pkg::NUM_DIGITS - 1) begin : g_top
				sida_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctrl     (ctrl),
					.bit_in   (bit_chain[gi]),
					.digit_in (digit_in_w[gi]),
					.bit_out  (),
					.digit    (digits_w[gi])
				);
			end else begin : g_mid
				sida_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctrl     (ctrl),
					.bit_in   (bit_chain[gi]),
					.digit_in (digit_in_w[gi]),
					.bit_out  (bit_chain[gi+1]),
					.digit    (digits_w[gi])
				);
			end
		end
	endgenerate

	assign digit_top = digits_w[sida_pkg::NUM_DIGITS-1];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sida_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, cell control and character generation
	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		skip      = !started_q && (digit_top == 4'd0) && (dcnt_q != DCNT_W'(1));
		in_stall  = (state_q != sida_pkg::ST_IDLE);
		accept    = in_valid && !in_stall;
		state_d   = state_q;
		ctrl      = '0;
		emit      = 1'b0;
		emit_char = sida_pkg::CH_ZERO + {4'd0, digit_top};
		emit_last = 1'b0;
		unique case (state_q)
			sida_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctrl.clear = 1'b1;
					state_d    = sida_pkg::ST_CONV;
				end
			end
			sida_pkg::ST_CONV: begin
				ctrl.dabble = 1'b1;
				if (bcnt_q == BCNT_W'(sida_pkg::VALUE_W - 1)) begin
					state_d = neg_q ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
				end
			end
			sida_pkg::ST_SIGN: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = sida_pkg::CH_MINUS;
					state_d   = sida_pkg::ST_DIGITS;
				end
			end
			sida_pkg::ST_DIGITS: begin
				if (skip) begin
					ctrl.shift = 1'b1;
				end else if (out_free) begin
					emit       = 1'b1;
					emit_last  = (dcnt_q == DCNT_W'(1)) && !nl_q;
					ctrl.shift = 1'b1;
					if (dcnt_q == DCNT_W'(1)) begin
						state_d = nl_q ? sida_pkg::ST_NEWLINE : sida_pkg::ST_IDLE;
					end
				end
			end
			sida_pkg::ST_NEWLINE: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = sida_pkg::CH_NEWLINE;
					emit_last = 1'b1;
					state_d   = sida_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sida_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer control: counters, sign and newline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q    <= '0;
			dcnt_q    <= '0;
			started_q <= 1'b0;
			neg_q     <= 1'b0;
			nl_q      <= 1'b0;
		end else if (accept) begin
			bcnt_q    <= '0;
			dcnt_q    <= DCNT_W'(sida_pkg::NUM_DIGITS);
			started_q <= 1'b0;
			neg_q     <= value[31];
			nl_q      <= append_newline;
		end else begin
			if (ctrl.dabble) begin
				bcnt_q <= bcnt_q + BCNT_W'(1);
			end
			if (ctrl.shift) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
				if (!skip) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	// magnitude shift register feeding the cell chain
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_w;
		end else if (ctrl.dabble) begin
			mag_q <= {mag_q[sida_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

/* hdl/sida_chk.sv */
// Port-level checker for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sida_pkg (character codes).
module sida_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] value,
	input logic        append_newline,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  char_code,
	input logic        last
);

	// stalled output character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
		else $error("stalled output character changed");

	// an accepted integer keeps the converter busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while converting");

	// a newline always ends the text
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == sida_pkg::CH_NEWLINE) |-> last)
		else $error("newline not marked last");

	// a minus sign never ends the text
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == sida_pkg::CH_MINUS) |-> !last)
		else $error("minus sign marked last");

	// only sign, digit or newline codes appear
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == sida_pkg::CH_MINUS) ||
			(char_code == sida_pkg::CH_NEWLINE) ||
			((char_code >= sida_pkg::CH_ZERO) && (char_code <= sida_pkg::CH_ZERO + 8'd9)))
		else $error("unexpected character code");

endmodule

bind signed_int_to_decimal_ascii sida_chk u_sida_chk (.*);

/* sim/decimal_text_check.sv */
// Watches both channels of signed_int_to_decimal_ascii, builds the expected text
// of every accepted integer and compares it character by character with the output.
// Depends on sida_pkg for the character codes and the digit count.
module decimal_text_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [31:0]       value,
	input  logic              append_newline,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        char_code,
	input  logic              last,
	output int unsigned       mismatches,
	output int unsigned       chars_pending,
	output int unsigned       chars_checked
);

	localparam logic [31:0] DECIMAL_BASE = 32'd10;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// characters still owed by the block, oldest first
	text_char_t text_q[$];

	// Append the decimal text of one integer to the queue
	function automatic void predict_text(input logic [31:0] v, input logic nl);
		logic [31:0] mag;
		logic [3:0]  dig [sida_pkg::NUM_DIGITS];
		int          nd;
		mag = v[31] ? (~v + 32'd1) : v;
		nd = 0;
		// at least one digit, so zero yields "0"
		do begin
			dig[nd] = 4'(mag % DECIMAL_BASE);
			mag = mag / DECIMAL_BASE;
			nd++;
		end while (mag != 32'd0);
		if (v[31]) begin
			text_q.push_back('{sida_pkg::CH_MINUS, 1'b0});
		end
		for (int i = nd - 1; i >= 0; i--) begin
			text_q.push_back('{8'(sida_pkg::CH_ZERO + dig[i]), (i == 0) && !nl});
		end
		if (nl) begin
			text_q.push_back('{sida_pkg::CH_NEWLINE, 1'b1});
		end
	endfunction

	// Output side is checked before the input side: a character can never
	// belong to an integer taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			text_q.delete();
			mismatches    = 0;
			chars_pending = 0;
			chars_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				chars_checked++;
				if (text_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("ERROR: unexpected character code %0d last %0b",
							char_code, last);
				end else begin
					want = text_q.pop_front();
					if (char_code !== want.code || last !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("ERROR: char expected %0d last %0b, got %0d last %0b",
								want.code, want.last, char_code, last);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_text(value, append_newline);
			chars_pending = text_q.size();
		end
	end

endmodule

/* sim/signed_int_to_decimal_ascii_tb.sv */
// Top of the testbench for signed_int_to_decimal_ascii: clock, reset, integer
// stimulus, output stall pattern and the verdict.
// Depends on the block and decimal_text_check.
module signed_int_to_decimal_ascii_tb;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic [31:0] value          = 32'd0;
	logic        append_newline = 1'b0;
	logic        out_stall      = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  char_code;
	logic        last;

	int unsigned mismatches;
	int unsigned chars_pending;
	int unsigned chars_checked;

	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;
	bit          hold_req     = 1'b0;
	int unsigned cycle_count  = 0;
	int unsigned sent_items   = 0;
	int unsigned sent_neg     = 0;

	// edge values, each sent with and without a newline
	logic [31:0] dir_vals [12] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd100, 32'd999999999, 32'd1000000000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF6, 32'hC465_3601
	};

	signed_int_to_decimal_ascii u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.append_newline (append_newline),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_code      (char_code),
		.last           (last)
	);

	decimal_text_check u_text_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.append_newline (append_newline),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_code      (char_code),
		.last           (last),
		.mismatches     (mismatches),
		.chars_pending  (chars_pending),
		.chars_checked  (chars_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d characters still owed",
				cycle_count, chars_pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Mix of full-range words, short numbers, powers of ten and the range ends
	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: return 32'($urandom_range(999));
			3: return ~32'($urandom_range(999)) + 32'd1;
			4: begin
				p = 32'd1;
				repeat ($urandom_range(9)) p = p * 32'd10;
				p = p + 32'($urandom_range(2)) - 32'd1;
				return $urandom_range(1) ? (~p + 32'd1) : p;
			end
			default: return $urandom_range(1) ? 32'h8000_0000 + 32'($urandom_range(3))
				: 32'h7FFF_FFFF - 32'($urandom_range(3));
		endcase
	endfunction

	// Offer one integer and wait for its transfer
	task automatic push_value(input logic [31:0] v, input logic nl);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			value <= $urandom;
			append_newline <= 1'($urandom_range(1));
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		append_newline <= nl;
		do @(posedge clk); while (in_stall);
		sent_items++;
		if (v[31]) sent_neg++;
	endtask

	task automatic run_phase(input int unsigned gap, input int unsigned stall,
			input int unsigned count, input bit hold);
		send_gap_pct = gap;
		stall_pct = stall;
		if (hold) hold_req = 1'b1;
		repeat (count) push_value(pick_value(), 1'($urandom_range(1)));
	endtask

	// Stimulus and verdict
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed values with and without newline
		for (int k = 0; k < 2; k++) begin
			foreach (dir_vals[i]) push_value(dir_vals[i], 1'(k));
		end

		run_phase(0, 0, 40, 1'b0);
		run_phase(49, 0, 40, 1'b0);
		run_phase(0, 49, 40, 1'b0);
		run_phase(13, 13, 28, 1'b0);
		// output held off while integers keep coming
		run_phase(0, 0, 28, 1'b1);
		in_valid <= 1'b0;

		do @(posedge clk); while (chars_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d integers (%0d negative) into %0d checked characters,",
			sent_items, sent_neg, chars_checked);
		$display("under free flow, sender gaps, output stalls, both, and a long hold-off.");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
